// ----- hdl/wpm_pkg.sv -----
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared constants and types for the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

  localparam int MAX_PATTERN_DEF = 32;

  localparam logic [7:0] SYM_STAR = 8'd42;
  localparam logic [7:0] SYM_ANY  = 8'd63;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;
  localparam logic [1:0] CMD_TEXT   = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] sym;
    logic       is_star;
    logic       is_any;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

// ----- hdl/wpm_front.sv -----
// ----------------------------------------------------------------------------
// wpm_front
// Accepts input words, decodes wildcard symbols and holds them in a
// two-entry queue for the matcher core.
// ----------------------------------------------------------------------------
module wpm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     command,
  input  logic [7:0]     symbol,
  output wpm_pkg::head_t head,
  input  logic           pop
);

  wpm_pkg::entry_t slots [2];
  wpm_pkg::entry_t incoming;
  logic [1:0]      count;
  logic            wr_ptr;
  logic            rd_ptr;
  logic            push;
  logic            take;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign take     = pop && (count != 2'd0);

  always_comb begin
    incoming.cmd     = command;
    incoming.sym     = symbol;
    incoming.is_star = (symbol == wpm_pkg::SYM_STAR);
    incoming.is_any  = (symbol == wpm_pkg::SYM_ANY);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !take) begin
        count <= count + 2'd1;
      end else if (take && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_comb begin
    head.valid = (count != 2'd0);
    head.entry = slots[rd_ptr];
  end

endmodule

// ----- hdl/wpm_back.sv -----
// ----------------------------------------------------------------------------
// wpm_back
// Pattern store and bit-parallel active set; executes one queued word per
// cycle unless the result word is stalled, and registers the result word.
// ----------------------------------------------------------------------------
module wpm_back #(
  parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  wpm_pkg::head_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           matched,
  output logic           no_active,
  output logic           pattern_overflow
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [7:0]             pat_byte [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] pat_any;
  logic [MAX_PATTERN:0]   star;
  logic [MAX_PATTERN:0]   active;
  logic [LEN_W-1:0]       len;
  logic                   ovf;

  logic [MAX_PATTERN:0]   star_next;
  logic [MAX_PATTERN:0]   active_next;
  logic [LEN_W-1:0]       len_next;
  logic                   ovf_next;
  logic                   wr_en;
  logic [MAX_PATTERN-1:0] hit;
  logic                   room;

  assign pop  = head.valid && (!out_valid || !out_stall);
  assign room = (len < LEN_W'(MAX_PATTERN));

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      hit[i] = (LEN_W'(i) < len) && active[i] &&
               (pat_any[i] || (pat_byte[i] == head.entry.sym));
    end
  end

  always_comb begin
    star_next   = star;
    active_next = active;
    len_next    = len;
    ovf_next    = ovf;
    wr_en       = 1'b0;
    case (head.entry.cmd)
      wpm_pkg::CMD_CLEAR: begin
        star_next   = '0;
        active_next = (MAX_PATTERN + 1)'(1);
        len_next    = '0;
        ovf_next    = 1'b0;
      end
      wpm_pkg::CMD_APPEND: begin
        if (head.entry.is_star) begin
          star_next[len] = 1'b1;
        end else if (room) begin
          wr_en    = 1'b1;
          len_next = len + LEN_W'(1);
        end else begin
          ovf_next = 1'b1;
        end
      end
      wpm_pkg::CMD_START: begin
        active_next = (MAX_PATTERN + 1)'(1);
      end
      wpm_pkg::CMD_TEXT: begin
        active_next = (active & star) | {hit, 1'b0};
      end
      default: begin
        active_next = active;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (pop && wr_en && (len == LEN_W'(j))) begin
        pat_byte[j] <= head.entry.sym;
        pat_any[j]  <= head.entry.is_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      star      <= '0;
      active    <= (MAX_PATTERN + 1)'(1);
      len       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        star      <= star_next;
        active    <= active_next;
        len       <= len_next;
        ovf       <= ovf_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      matched          <= active_next[len_next];
      no_active        <= ~|active_next;
      pattern_overflow <= ovf_next;
    end
  end

endmodule

// ----- hdl/wildcard_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Glob matcher with star and any-one wildcards over a bit-parallel NFA.
//
// Input channel (in_valid / in_stall): one word carries command and symbol:
// clear pattern, append pattern symbol, start text, or text byte.
// Output channel (out_valid / out_stall): one result word per input word,
// in order: matched, no_active, pattern_overflow after that word.
// Throughput: one word per clock while the receiver does not stall; every
// position of the active set is updated in parallel.
// An accepted word is queued; its result is registered when the core takes it.
// A two-entry queue sits between the input decoder and the matcher core;
// the core advances only when the output register is empty or being taken.
// A stalled receiver holds the result word; the queue then fills and
// in_stall rises after two more words.
// Reset: empty pattern, no star loops, active set at position zero,
// overflow flag clear, queue and output register empty.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher #(
  parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched,
  output logic       no_active,
  output logic       pattern_overflow
);

  wpm_pkg::head_t head;
  logic           pop;

  wpm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .symbol   (symbol),
    .head     (head),
    .pop      (pop)
  );

  wpm_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .matched          (matched),
    .no_active        (no_active),
    .pattern_overflow (pattern_overflow)
  );

endmodule

// ----- dv/wildcard_pattern_matcher_tb.sv -----
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_tb
// Self-checking testbench for the glob matcher with star and any-one symbols.
// A short directed sequence is followed by random glob runs (clear, pattern
// load, one or more texts built mostly to fit the pattern) mixed with random
// command noise. A cycle-free predictor tracks the NFA active set and queues
// the expected flags for each accepted word; the monitor compares every
// result word against them while the sender idles in bursts and the
// receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAT     = wpm_pkg::MAX_PATTERN_DEF;
  localparam int WORD_TARGET = 1150;
  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_B = 8'h62;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] sym;
  } cmd_word_t;

  typedef struct packed {
    logic matched;
    logic no_active;
    logic overflow;
  } match_flags_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] command = wpm_pkg::CMD_CLEAR;
  logic [7:0] symbol = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       matched;
  logic       no_active;
  logic       pattern_overflow;

  wildcard_pattern_matcher dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .symbol           (symbol),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .matched          (matched),
    .no_active        (no_active),
    .pattern_overflow (pattern_overflow)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]     glob_byte [MAX_PAT];
  logic [MAX_PAT:0] star_at;
  logic [MAX_PAT:0] live_pos;
  int             glob_len;
  logic           overflow_seen;

  cmd_word_t      word_q[$];
  match_flags_t   flags_due[$];
  int             n_queued = 0;
  int             n_sent = 0;
  int             n_text = 0;
  int             n_results = 0;
  int             n_matched = 0;
  int             n_overflow = 0;
  int             errors = 0;

  function automatic void reset_glob();
    star_at       = '0;
    live_pos      = (MAX_PAT + 1)'(1);
    glob_len      = 0;
    overflow_seen = 1'b0;
  endfunction

  function automatic match_flags_t step_glob(cmd_word_t w);
    logic [MAX_PAT:0] nxt;
    match_flags_t     f;
    case (w.cmd)
      wpm_pkg::CMD_CLEAR: begin
        reset_glob();
      end
      wpm_pkg::CMD_APPEND: begin
        if (w.sym == wpm_pkg::SYM_STAR) begin
          star_at[glob_len] = 1'b1;
        end else if (glob_len < MAX_PAT) begin
          glob_byte[glob_len] = w.sym;
          glob_len++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      wpm_pkg::CMD_START: begin
        live_pos = (MAX_PAT + 1)'(1);
      end
      default: begin
        nxt = '0;
        for (int i = 0; i <= glob_len; i++) begin
          if (live_pos[i]) begin
            if (star_at[i]) nxt[i] = 1'b1;
            if (i < glob_len) begin
              if (glob_byte[i] == w.sym || glob_byte[i] == wpm_pkg::SYM_ANY) nxt[i+1] = 1'b1;
            end
          end
        end
        live_pos = nxt;
      end
    endcase
    f.matched   = live_pos[glob_len];
    f.no_active = (live_pos == '0);
    f.overflow  = overflow_seen;
    return f;
  endfunction

  function automatic void send(logic [1:0] c, logic [7:0] s);
    word_q.push_back('{cmd: c, sym: s});
    n_queued++;
  endfunction

  function automatic logic [7:0] pick_glob_sym();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return wpm_pkg::SYM_STAR;
    if (r < 4) return wpm_pkg::SYM_ANY;
    if (r < 7) return CHAR_A;
    if (r < 8) return CHAR_B;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r < 3) return CHAR_A;
    if (r < 4) return CHAR_B;
    if (r < 5) return wpm_pkg::SYM_STAR;
    if (r < 6) return wpm_pkg::SYM_ANY;
    return 8'($urandom);
  endfunction

  function automatic void build_glob_run();
    logic [7:0] pat[$];
    logic [7:0] s;
    bit         long_run;
    int         n_sym;
    long_run = ($urandom_range(0, 19) == 0);
    n_sym    = long_run ? $urandom_range(MAX_PAT - 2, MAX_PAT + 4) : $urandom_range(0, 8);
    send(wpm_pkg::CMD_CLEAR, 8'($urandom));
    for (int k = 0; k < n_sym; k++) begin
      s = (long_run && $urandom_range(0, 7) != 0) ? CHAR_A : pick_glob_sym();
      pat.push_back(s);
      send(wpm_pkg::CMD_APPEND, s);
    end
    repeat ($urandom_range(1, 3)) begin
      send(wpm_pkg::CMD_START, 8'($urandom));
      foreach (pat[k]) begin
        if (pat[k] == wpm_pkg::SYM_STAR) begin
          repeat ($urandom_range(0, 3)) send(wpm_pkg::CMD_TEXT, pick_text_byte());
        end else if (pat[k] == wpm_pkg::SYM_ANY) begin
          send(wpm_pkg::CMD_TEXT, 8'($urandom));
        end else begin
          send(wpm_pkg::CMD_TEXT, ($urandom_range(0, 15) == 0) ? pick_text_byte() : pat[k]);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send(wpm_pkg::CMD_TEXT, pick_text_byte());
      end
      if ($urandom_range(0, 7) == 0) send(wpm_pkg::CMD_APPEND, pick_glob_sym());
    end
  endfunction

  function automatic void check_flag(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      errors++;
    end
  endfunction

  // driver
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk) begin
    cmd_word_t w;
    logic      nxt_valid;
    if (rst) begin
      in_valid <= 1'b0;
      reset_glob();
    end else begin
      if (in_valid && !in_stall) begin
        flags_due.push_back(step_glob('{cmd: command, sym: symbol}));
        n_sent++;
        if (command == wpm_pkg::CMD_TEXT) n_text++;
      end
      if (!in_valid || !in_stall) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (word_q.size() > 0) begin
          w = word_q.pop_front();
          command   <= w.cmd;
          symbol    <= w.sym;
          nxt_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_valid <= nxt_valid;
      end
    end
  end

  // monitor
  int stall_mode = 0;
  int mode_left = 50;
  int stall_phase = 0;

  always @(posedge clk) begin
    match_flags_t want;
    logic         nxt_stall;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (flags_due.size() == 0) begin
          $error("result word with no prediction pending");
          errors++;
        end else begin
          want = flags_due.pop_front();
          check_flag("matched", want.matched, matched);
          check_flag("no_active", want.no_active, no_active);
          check_flag("pattern_overflow", want.overflow, pattern_overflow);
          if (want.matched) n_matched++;
          if (want.overflow) n_overflow++;
        end
      end
      mode_left--;
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end
      stall_phase++;
      case (stall_mode)
        0:       nxt_stall = 1'b0;
        1:       nxt_stall = ($urandom_range(0, 3) == 0);
        2:       nxt_stall = ($urandom_range(0, 3) != 0);
        default: nxt_stall = (stall_phase % 3 == 0);
      endcase
      out_stall <= nxt_stall;
    end
  end

  initial begin
    // right after reset, then wildcard corners
    send(wpm_pkg::CMD_TEXT, 8'h00);
    send(wpm_pkg::CMD_START, 8'hFF);
    send(wpm_pkg::CMD_CLEAR, 8'hFF);
    send(wpm_pkg::CMD_APPEND, wpm_pkg::SYM_STAR);
    send(wpm_pkg::CMD_APPEND, wpm_pkg::SYM_STAR);
    send(wpm_pkg::CMD_START, 8'h00);
    send(wpm_pkg::CMD_TEXT, 8'h00);
    send(wpm_pkg::CMD_APPEND, wpm_pkg::SYM_ANY);
    send(wpm_pkg::CMD_APPEND, 8'hFF);
    send(wpm_pkg::CMD_APPEND, wpm_pkg::SYM_STAR);
    send(wpm_pkg::CMD_START, 8'h00);
    send(wpm_pkg::CMD_TEXT, 8'h00);
    send(wpm_pkg::CMD_TEXT, 8'hFF);
    send(wpm_pkg::CMD_TEXT, wpm_pkg::SYM_STAR);
    send(wpm_pkg::CMD_CLEAR, 8'h00);
    send(wpm_pkg::CMD_APPEND, wpm_pkg::SYM_ANY);
    send(wpm_pkg::CMD_START, 8'h00);
    send(wpm_pkg::CMD_TEXT, wpm_pkg::SYM_STAR);
    send(wpm_pkg::CMD_TEXT, wpm_pkg::SYM_ANY);
    while (n_queued < WORD_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) send(2'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        build_glob_run();
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (n_sent == n_queued && flags_due.size() == 0);
    repeat (8) @(posedge clk);
    $display("%0d words driven (%0d text bytes), %0d result words checked",
             n_sent, n_text, n_results);
    $display("%0d results reported a match, %0d carried the overflow flag",
             n_matched, n_overflow);
    if (errors == 0 && flags_due.size() == 0) begin
      $display("wildcard_pattern_matcher_tb OK");
    end else begin
      $display("wildcard_pattern_matcher_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("wildcard_pattern_matcher_tb NOT OK");
    $finish;
  end

endmodule
